/* src/crba_pkg.sv */
// ----------------------------------------------------------------------------
// crba_pkg
// Shared types, widths and constants for the circular row box average.
// ----------------------------------------------------------------------------
package crba_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = ADDR_W + 1;
  localparam int ROW_W     = 3;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = WIDTH_W + FRAC_W;
  localparam int SAMPLE_W  = 32;
  localparam int NARROW_W  = 16;
  localparam int SUM_W     = SAMPLE_W + WIDTH_W;
  localparam int NUM_W     = SUM_W + 2;
  localparam int DIV_W     = SUM_W + 1;
  localparam int DEN_W     = WIDTH_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = WIDTH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IS_WIDE = 1'b1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0]           row_index;
    logic [ADDR_W-1:0]          pixel_index;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [ADDR_W-1:0]          pixel_out;
  } out_item_t;

  // round(32768 * (1 - sin(r*pi/16)))
  function automatic logic [FRAC_W-1:0] half_frac(input logic [ROW_W-1:0] row);
    logic [FRAC_W-1:0] f;
    case (row)
      3'd0:    f = 16'd32768;
      3'd1:    f = 16'd26375;
      3'd2:    f = 16'd20228;
      3'd3:    f = 16'd14563;
      3'd4:    f = 16'd9598;
      3'd5:    f = 16'd5522;
      3'd6:    f = 16'd2494;
      default: f = 16'd630;
    endcase
    return f;
  endfunction

endpackage

/* src/crba_mem.sv */
// ----------------------------------------------------------------------------
// crba_mem
// Row sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crba_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [crba_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [crba_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [crba_pkg::ADDR_W-1:0]   rd_addr,
  output logic [crba_pkg::SAMPLE_W-1:0] rd_data
);
  import crba_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_WIDTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/crba_div.sv */
// ----------------------------------------------------------------------------
// crba_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module crba_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [crba_pkg::DIV_W-1:0] dividend,
  input  logic [crba_pkg::DEN_W-1:0] divisor,
  output logic                       done,
  output logic [crba_pkg::DIV_W-1:0] quotient,
  output logic [crba_pkg::DEN_W-1:0] remainder
);
  import crba_pkg::*;

  logic                 run_r,  run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [DIV_W-1:0]     quo_r,  quo_nxt;
  logic [DEN_W-1:0]     rem_r,  rem_nxt;
  logic [DEN_W-1:0]     den_r,  den_nxt;
  logic [DEN_W:0]       shifted;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
    end else if (run_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* src/circular_row_box_average.sv */
// ----------------------------------------------------------------------------
// circular_row_box_average
// Circular box average over one stored row, half-width set by a row index.
//
//   channel  ports                           direction  handshake
//   input    start, busy, in_payload         in         start & !busy
//   result   out_strobe, out_payload         out        one-cycle strobe
//   config   cfg_we, cfg_index, cfg_wdata    in         cfg_we
//
// A load transaction leaves busy low.
// A request runs a multiply, the pixel modulo on the shared divider, the
// sum, one sample added per cycle from the row memory read port, and the
// final quotient on the shared divider, plus bookkeeping.
// Synchronous active-low reset clears control state and the load position.
// The receiver cannot stall; each result is presented for one cycle.
// ----------------------------------------------------------------------------
module circular_row_box_average (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  crba_pkg::in_item_t             in_payload,
  output logic                           out_strobe,
  output crba_pkg::out_item_t            out_payload,
  input  logic                           cfg_we,
  input  logic [crba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crba_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import crba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [WIDTH_W-1:0] row_width_r;
  logic              wide_r;
  logic [ADDR_W-1:0] load_pos_r, load_pos_nxt;
  logic [ADDR_W-1:0] pix_r, pix_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WIDTH_W-1:0] w_r, w_nxt;
  logic [WIDTH_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic              neg_r, neg_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_r, out_nxt;

  logic [WIDTH_W-1:0]  width;
  logic                accept;
  logic                do_load;
  logic [PROD_W-1:0]   prod;
  logic [WIDTH_W-1:0]  n_val;
  logic [WIDTH_W:0]    start_sum;
  logic [WIDTH_W:0]    start_idx;
  logic [WIDTH_W-1:0]  load_inc;
  logic [WIDTH_W-1:0]  idx_inc;
  logic                rd_en;
  logic [SAMPLE_W-1:0] rd_data;
  logic signed [SUM_W-1:0] ext;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]    num_abs;
  logic [SAMPLE_W-1:0] q_signed;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;
  logic [DEN_W-1:0]    div_rem;

  always_comb begin
    if (row_width_r == '0) begin
      width = WIDTH_W'(1);
    end else if (row_width_r > WIDTH_W'(MAX_WIDTH)) begin
      width = WIDTH_W'(MAX_WIDTH);
    end else begin
      width = row_width_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= WIDTH_W'(MAX_WIDTH);
      wide_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_WIDTH:      row_width_r <= cfg_wdata;
        CFG_SAMPLE_IS_WIDE: wide_r      <= cfg_wdata[0];
        default:            ;
      endcase
    end
  end

  assign busy    = state_r != S_IDLE;
  assign accept  = start && !busy;
  assign do_load = accept && in_payload.opcode == OP_LOAD;

  assign load_inc = {1'b0, load_pos_r} + 1'b1;
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign prod     = width * half_frac(row_r);
  assign n_val    = {w_r[WIDTH_W-2:0], 1'b1};
  assign start_sum = {1'b0, div_rem[WIDTH_W-1:0]} + {1'b0, width - w_r};
  assign start_idx = (start_sum >= {1'b0, width}) ? start_sum - {1'b0, width} : start_sum;
  assign rd_en     = state_r == S_SUM && iss_cnt_r != '0;

  assign ext = wide_r ? SUM_W'(signed'(rd_data))
                      : SUM_W'(signed'(rd_data[NARROW_W-1:0]));
  assign num     = {sum_r[SUM_W-1], sum_r, 1'b0} + NUM_W'(n_val);
  assign num_abs = num[NUM_W-1] ? -num : num;
  assign q_signed = neg_r ? -div_quo[SAMPLE_W-1:0] : div_quo[SAMPLE_W-1:0];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(pix_r);
    div_divisor  = DEN_W'(width);
    if (state_r == S_MUL) begin
      div_start = 1'b1;
    end else if (state_r == S_DIVS) begin
      div_start    = 1'b1;
      div_dividend = num_abs[DIV_W-1:0];
      div_divisor  = {n_val, 1'b0};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    load_pos_nxt   = load_pos_r;
    pix_nxt        = pix_r;
    row_nxt        = row_r;
    w_nxt          = w_r;
    iss_cnt_nxt    = iss_cnt_r;
    idx_nxt        = idx_r;
    rd_pend_nxt    = 1'b0;
    sum_nxt        = sum_r;
    neg_nxt        = neg_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    case (state_r)
      S_IDLE: begin
        if (do_load) begin
          load_pos_nxt = (load_inc >= width) ? '0 : load_inc[ADDR_W-1:0];
        end else if (accept) begin
          pix_nxt   = in_payload.pixel_index;
          row_nxt   = in_payload.row_index;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        w_nxt     = prod[PROD_W-1:FRAC_W];
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (div_done) begin
          idx_nxt     = start_idx[ADDR_W-1:0];
          iss_cnt_nxt = n_val;
          sum_nxt     = '0;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        if (rd_en) begin
          idx_nxt     = (idx_inc >= width) ? '0 : idx_inc[ADDR_W-1:0];
          iss_cnt_nxt = iss_cnt_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          sum_nxt = sum_r + ext;
        end
        if (!rd_en && !rd_pend_r) begin
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        neg_nxt   = num[NUM_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          out_strobe_nxt    = 1'b1;
          out_nxt.pixel_out = pix_r;
          out_nxt.average   = wide_r ? q_signed
                                     : SAMPLE_W'(signed'(q_signed[NARROW_W-1:0]));
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      load_pos_r   <= '0;
      iss_cnt_r    <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_pos_r   <= load_pos_nxt;
      iss_cnt_r    <= iss_cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    row_r <= row_nxt;
    w_r   <= w_nxt;
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

  crba_mem u_mem (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (load_pos_r),
    .wr_data (in_payload.sample),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  crba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> state_r == S_IDLE)
    else $error("result strobe outside idle");
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MOD || state_r == S_DIV))
    else $error("divider finished in an unexpected state");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> {1'b0, idx_r} < width)
    else $error("read address beyond row width");
  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    do_load |=> state_r == S_IDLE && !out_strobe)
    else $error("load transaction left idle");
  a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(rd_en))
    else $error("read data flagged without a read");
`endif

endmodule

/* tb/crba_checker.sv */
// ----------------------------------------------------------------------------
// crba_checker
// Watches the input, result and configuration ports of the circular row box
// average. It keeps its own copy of the row and the registers, computes each
// requested average when the request transaction is taken, and compares every
// result strobe against the oldest outstanding average, field by field.
// ----------------------------------------------------------------------------
module crba_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  crba_pkg::in_item_t             in_payload,
  input  logic                           out_strobe,
  input  crba_pkg::out_item_t            out_payload,
  input  logic                           cfg_we,
  input  logic [crba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crba_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                             mismatch_count,
  output int                             averages_pending,
  output int                             loads_seen,
  output int                             requests_seen,
  output int                             averages_checked
);
  import crba_pkg::*;

  // half-width fractions, row 7 down to row 0
  localparam logic [7:0][FRAC_W-1:0] WINDOW_FRAC = {
    16'd630, 16'd2494, 16'd5522, 16'd9598,
    16'd14563, 16'd20228, 16'd26375, 16'd32768
  };

  logic [SAMPLE_W-1:0]  row_copy [MAX_WIDTH];
  int unsigned          next_slot;
  logic [CFG_DAT_W-1:0] width_reg;
  logic                 wide_mode;
  out_item_t            average_queue [$];
  out_item_t            wanted;
  int                   errs;

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic out_item_t predict_average(input logic [ROW_W-1:0] row,
                                                input logic [ADDR_W-1:0] pix);
    int unsigned         wd;
    int unsigned         half;
    int unsigned         count;
    int unsigned         pos;
    int unsigned         k;
    longint              total;
    longint              quot;
    logic [SAMPLE_W-1:0] s;
    out_item_t           res;
    wd    = active_width();
    half  = (wd * WINDOW_FRAC[row]) >> FRAC_W;
    count = 2 * half + 1;
    pos   = (pix % wd + wd - half % wd) % wd;
    total = 0;
    for (k = 0; k < count; k++) begin
      s = row_copy[pos];
      if (wide_mode) total += longint'($signed(s));
      else total += longint'($signed(s[NARROW_W-1:0]));
      pos = (pos + 1 >= wd) ? 0 : pos + 1;
    end
    quot = (2 * total + longint'(count)) / (2 * longint'(count));
    if (wide_mode) res.average = quot[SAMPLE_W-1:0];
    else res.average = {{(SAMPLE_W-NARROW_W){quot[NARROW_W-1]}}, quot[NARROW_W-1:0]};
    res.pixel_out = pix;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      next_slot        = 0;
      width_reg        = CFG_DAT_W'(MAX_WIDTH);
      wide_mode        = 1'b0;
      average_queue.delete();
      mismatch_count   <= 0;
      loads_seen       <= 0;
      requests_seen    <= 0;
      averages_checked <= 0;
    end else begin
      errs = 0;
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == CFG_SAMPLE_IS_WIDE) wide_mode = cfg_wdata[0];
      end

      if (out_strobe) begin
        if (average_queue.size() == 0) begin
          $error("unexpected result: pixel_out %0d average %0d",
                 out_payload.pixel_out, out_payload.average);
          errs++;
        end else begin
          wanted = average_queue.pop_front();
          if (out_payload.average !== wanted.average) begin
            $error("average: expected %0d, got %0d", wanted.average, out_payload.average);
            errs++;
          end
          if (out_payload.pixel_out !== wanted.pixel_out) begin
            $error("pixel_out: expected %0d, got %0d", wanted.pixel_out,
                   out_payload.pixel_out);
            errs++;
          end
          averages_checked <= averages_checked + 1;
        end
      end
      mismatch_count <= mismatch_count + errs;

      if (start && !busy) begin
        if (in_payload.opcode == OP_LOAD) begin
          row_copy[next_slot % MAX_WIDTH] = in_payload.sample;
          next_slot = (next_slot % MAX_WIDTH) + 1;
          if (next_slot >= active_width()) next_slot = 0;
          loads_seen <= loads_seen + 1;
        end else begin
          average_queue.push_back(predict_average(in_payload.row_index,
                                                  in_payload.pixel_index));
          requests_seen <= requests_seen + 1;
        end
      end
    end
    averages_pending <= average_queue.size();
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the circular row box average. Runs a series of row width and
// sample mode settings. The first two keep the full row width and fill only
// the start of the row, requesting narrow windows inside it; the rest load a
// full row each. Directed and random request and load transactions follow,
// with varying sender gaps. Prediction and comparison live in crba_checker;
// this module drives and gives a verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import crba_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 30;
  // half-width of row 7 at the full row width
  localparam int EDGE_HALF     = 9;

  typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_ALTERNATE} fill_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_payload;
  logic                 out_strobe;
  out_item_t            out_payload;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  int mismatch_count;
  int averages_pending;
  int loads_seen;
  int requests_seen;
  int averages_checked;
  int idle_pct;
  int settings_run;
  int loads_sent;
  int quiet_cycles = 0;

  circular_row_box_average dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_strobe  (out_strobe),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  crba_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_payload       (in_payload),
    .out_strobe       (out_strobe),
    .out_payload      (out_payload),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .averages_pending (averages_pending),
    .loads_seen       (loads_seen),
    .requests_seen    (requests_seen),
    .averages_checked (averages_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("circular_row_box_average regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int active_width(input logic [CFG_DAT_W-1:0] wval);
    if (wval == '0) return 1;
    if (wval > MAX_WIDTH) return MAX_WIDTH;
    return wval;
  endfunction

  function automatic logic [SAMPLE_W-1:0] fill_value(input fill_t pattern, input int i);
    case (pattern)
      FILL_MAX:       return 32'h7FFF_7FFF;
      FILL_MIN:       return 32'h8000_8000;
      FILL_ALTERNATE: return i[0] ? 32'h7FFF_7FFF : 32'h8000_8000;
      default:        return $urandom();
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(input in_item_t item);
    start      <= 1'b1;
    in_payload <= item;
    while (busy) @(negedge clk);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic load_sample(input logic [SAMPLE_W-1:0] value);
    in_item_t item;
    item.opcode      = OP_LOAD;
    item.sample      = value;
    item.row_index   = ROW_W'($urandom_range(0, 7));
    item.pixel_index = ADDR_W'($urandom_range(0, MAX_WIDTH - 1));
    loads_sent++;
    send_item(item);
  endtask

  task automatic request_average(input logic [ROW_W-1:0] row,
                                 input logic [ADDR_W-1:0] pix);
    in_item_t item;
    item.opcode      = OP_REQUEST;
    item.sample      = $urandom();
    item.row_index   = row;
    item.pixel_index = pix;
    send_item(item);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (averages_pending != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [CFG_DAT_W-1:0] wval, input logic wide);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_WIDTH;
    cfg_wdata <= wval;
    @(negedge clk);
    cfg_index <= CFG_SAMPLE_IS_WIDE;
    cfg_wdata <= {(CFG_DAT_W-1)'($urandom_range(0, 1023)), wide};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one setting: optional register write, row load, optional directed requests, random traffic;
  // a non-zero fill loads only that many samples and keeps requests on
  // row 7 inside the samples loaded so far (full row width only)
  task automatic run_setting(input logic [CFG_DAT_W-1:0] wval, input logic wide,
                             input fill_t pattern, input bit do_write, input bit directed,
                             input int fill);
    int wd;
    int i;
    if (do_write) write_config(wval, wide);
    wd = active_width(wval);
    settings_run++;
    if (fill > 0) begin
      for (i = 0; i < fill; i++) load_sample(fill_value(pattern, i));
    end else begin
      // one extra load covers a load position left beyond a shrunk row
      for (i = 0; i <= wd; i++) load_sample(fill_value(pattern, i));
    end
    if (directed) begin
      for (i = 0; i < 8; i++) request_average(i[ROW_W-1:0], '0);
      request_average(3'd0, ADDR_W'(MAX_WIDTH - 1));
      request_average(3'd7, ADDR_W'(MAX_WIDTH - 1));
      request_average(3'd3, ADDR_W'(MAX_WIDTH / 2 - 1));
    end
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        load_sample(fill_value(pattern, $urandom()));
      end else if (fill > 0) begin
        request_average(3'd7,
                        ADDR_W'($urandom_range(EDGE_HALF, loads_sent - 1 - EDGE_HALF)));
      end else if ($urandom_range(0, 3) == 0) begin
        request_average(ROW_W'($urandom_range(0, 7)),
                        ADDR_W'($urandom_range(0, MAX_WIDTH - 1)));
      end else begin
        request_average(ROW_W'($urandom_range(0, 7)),
                        ADDR_W'($urandom_range(0, wd - 1)));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_payload   = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    settings_run = 0;
    loads_sent   = 0;
    idle_pct     = 10;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_setting(11'd1024, 1'b0, FILL_ALTERNATE, 1'b0, 1'b0, 40);
    run_setting(11'd2047, 1'b1, FILL_MAX,       1'b1, 1'b0, 20);
    run_setting(11'd1,    1'b1, FILL_MAX,       1'b1, 1'b0, 0);
    run_setting(11'd2,    1'b0, FILL_MIN,       1'b1, 1'b0, 0);
    run_setting(11'd0,    1'b0, FILL_RANDOM,    1'b1, 1'b0, 0);
    idle_pct = 69;
    run_setting(11'd3,    1'b1, FILL_MIN,       1'b1, 1'b0, 0);
    run_setting(11'd7,    1'b0, FILL_RANDOM,    1'b1, 1'b0, 0);
    run_setting(11'd16,   1'b1, FILL_ALTERNATE, 1'b1, 1'b0, 0);
    run_setting(11'd33,   1'b0, FILL_MAX,       1'b1, 1'b0, 0);
    idle_pct = 0;
    run_setting(11'd100,  1'b1, FILL_MIN,       1'b1, 1'b1, 0);
    run_setting(11'd5,    1'b0, FILL_RANDOM,    1'b1, 1'b0, 0);

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d width/mode settings: %0d loads, %0d requests, %0d averages checked.",
             settings_run, loads_seen, requests_seen, averages_checked);
    $display("Sender gaps at 10, 69 and 0 percent; %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("circular_row_box_average regression: pass");
    end else begin
      $display("circular_row_box_average regression: fail");
    end
    $finish;
  end

endmodule
